[sv/pba_pkg.sv]
// Shared constants, types and the helper function of the packed bit-field array.
`default_nettype none

package pba_pkg;

   // Number of stored bytes (one byte per entry)
   localparam int ENTRIES = 1024;

   // Payload widths
   localparam int CMD_W   = 1;
   localparam int IDX_W   = 10;
   localparam int VAL_W   = 8;
   localparam int WIDTH_W = 4;

   // Field width after reset
   localparam logic [WIDTH_W-1:0] WIDTH_RESET = 4'd6;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_READ  = 1'b0;
   localparam logic [CMD_W-1:0] CMD_WRITE = 1'b1;

   // Bit offset of a field and the byte that holds its first bit
   localparam int OFF_W  = IDX_W + WIDTH_W;
   localparam int BYTE_W = OFF_W - 3;

   // Even bytes and odd bytes sit in two banks so that a field's two bytes
   // can be read and written in the same cycle.
   localparam int EVEN_DEPTH = (ENTRIES + 1) / 2;
   localparam int ODD_DEPTH  = ENTRIES / 2;
   localparam int EVEN_AW    = (EVEN_DEPTH > 1) ? $clog2(EVEN_DEPTH) : 1;
   localparam int ODD_AW     = (ODD_DEPTH > 1) ? $clog2(ODD_DEPTH) : 1;

   // Where one field lies in the two banks
   typedef struct packed {
      logic               in_range;   // index below ENTRIES
      logic               has_next;   // the byte after the first one exists
      logic               odd_start;  // first byte sits in the odd bank
      logic [2:0]         bit_at;     // bit position inside the first byte
      logic [EVEN_AW-1:0] even_addr;
      logic [ODD_AW-1:0]  odd_addr;
   } loc_type;

   // Field width as used: zero counts as one, above eight counts as eight
   function automatic logic [WIDTH_W-1:0] eff_width(input logic [WIDTH_W-1:0] w);
      logic [WIDTH_W-1:0] r;
      r = w;
      if (w == '0) begin
         r = WIDTH_W'(1);
      end else if (w > WIDTH_W'(8)) begin
         r = WIDTH_W'(8);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[sv/pba_if.sv]
// Handshake channel interfaces: command input, read result, width register.
`default_nettype none

interface pba_req_if;
   logic                          valid;
   logic                          ready;
   logic [pba_pkg::CMD_W-1:0]     command;
   logic [pba_pkg::IDX_W-1:0]     index;
   logic [pba_pkg::VAL_W-1:0]     write_value;

   modport source (output valid, output command, output index, output write_value,
                   input ready);
   modport sink   (input valid, input command, input index, input write_value,
                   output ready);
endinterface

interface pba_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [pba_pkg::VAL_W-1:0]     read_value;

   modport source (output valid, output read_value, input ready);
   modport sink   (input valid, input read_value, output ready);
endinterface

interface pba_csr_if;
   logic                          valid;
   logic                          ready;
   logic [pba_pkg::WIDTH_W-1:0]   field_width;

   modport source (output valid, output field_width, input ready);
   modport sink   (input valid, input field_width, output ready);
endinterface

`default_nettype wire

[sv/pba_ram.sv]
// Generic single-port synchronous RAM with registered read data.
`default_nettype none

module pba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    addr,
   input  wire logic [WIDTH-1:0] wdata,
   output      logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port at the same address
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule

`default_nettype wire

[sv/pba_locate.sv]
// Maps an entry index and field width to the byte and bank addresses of the field.
`default_nettype none

module pba_locate (
   input  wire logic [pba_pkg::IDX_W-1:0]   index,
   input  wire logic [pba_pkg::WIDTH_W-1:0] width,
   output      pba_pkg::loc_type            loc
);

   logic [pba_pkg::OFF_W-1:0]  offset;
   logic [pba_pkg::BYTE_W-1:0] byte_at;
   logic [pba_pkg::BYTE_W-1:0] half;
   logic                       in_range;
   logic                       has_next;
   logic                       odd_start;

   // Bit offset of the field, first byte and its neighbor
   always_comb begin
      offset    = pba_pkg::OFF_W'(index) * pba_pkg::OFF_W'(width);
      byte_at   = offset[pba_pkg::OFF_W-1:3];
      half      = byte_at >> 1;
      odd_start = byte_at[0];
      in_range  = 32'(index) < 32'(pba_pkg::ENTRIES);
      has_next  = (32'(byte_at) + 32'd1) < 32'(pba_pkg::ENTRIES);
   end

   // Bank addresses; a missing neighbor byte reads address zero and is masked later
   always_comb begin
      loc.in_range  = in_range;
      loc.has_next  = has_next;
      loc.odd_start = odd_start;
      loc.bit_at    = offset[2:0];
      if (!odd_start) begin
         loc.even_addr = pba_pkg::EVEN_AW'(half);
      end else if (has_next) begin
         loc.even_addr = pba_pkg::EVEN_AW'(half + pba_pkg::BYTE_W'(1));
      end else begin
         loc.even_addr = '0;
      end
      if (odd_start || has_next) begin
         loc.odd_addr = pba_pkg::ODD_AW'(half);
      end else begin
         loc.odd_addr = '0;
      end
   end

endmodule

`default_nettype wire

[sv/pba_merge.sv]
// Extracts a field from a two-byte window and merges a new field value into it.
`default_nettype none

module pba_merge (
   input  wire logic [7:0]                  lo_byte,
   input  wire logic [7:0]                  hi_byte,
   input  wire logic [2:0]                  bit_at,
   input  wire logic [pba_pkg::WIDTH_W-1:0] width,
   input  wire logic [pba_pkg::VAL_W-1:0]   write_value,
   output      logic [pba_pkg::VAL_W-1:0]   field,
   output      logic [7:0]                  new_lo,
   output      logic [7:0]                  new_hi
);

   logic [8:0]  fmask;
   logic [15:0] word;
   logic [15:0] mask;
   logic [15:0] shifted_val;
   logic [15:0] merged;

   always_comb begin
      fmask       = (9'd1 << width) - 9'd1;
      word        = {hi_byte, lo_byte};
      mask        = 16'(fmask) << bit_at;
      shifted_val = (16'(write_value) & 16'(fmask)) << bit_at;
      field       = pba_pkg::VAL_W'((word >> bit_at) & 16'(fmask));
      merged      = (word & ~mask) | shifted_val;
      new_lo      = merged[7:0];
      new_hi      = merged[15:8];
   end

endmodule

`default_nettype wire

[sv/packed_bitfield_array_top.sv]
// Top level of the packed bit-field array: control, bank RAMs and result register.
//
// Use of the block:
//   req_bus carries commands (read or write, entry index, write value); a command
//   is transferred when valid and ready are both high. rsp_bus returns one
//   read_value for every read command and nothing for a write. csr_bus writes
//   the field width (1 to 8 bits, 0 taken as 1, above 8 taken as 8); it is
//   always ready; it must be written only while the block is idle, which the
//   block itself does not enforce. The fields lie in two byte-wide RAMs, even
//   bytes and odd bytes, so the two bytes a field can span are read together
//   in the transfer cycle and written back together in the following cycle.
//   Commands: a new command is not taken before the read-modify-write of the
//   bank RAMs for the last one is done (read in the transfer cycle, merge and
//   write back in the next); a read's field is registered after its merge.
//   Reset: the width returns to 6 and a clearing pass zeroes the RAMs, one
//   address of each bank per cycle; req_bus.ready stays low during that pass.
//   Stall: a read result waits in the output register until taken; a new command
//   is taken once that register is empty or being emptied in the same cycle.
`default_nettype none

module packed_bitfield_array_top (
   input  wire logic   clock,
   input  wire logic   reset,
   pba_req_if.sink     req_bus,
   pba_rsp_if.source   rsp_bus,
   pba_csr_if.sink     csr_bus
);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_MOD   = 2'd2;

   logic [1:0]                    state_ff, state_in;
   logic [pba_pkg::EVEN_AW-1:0]   clr_cnt_ff, clr_cnt_in;
   logic [pba_pkg::WIDTH_W-1:0]   width_ff;
   logic [pba_pkg::WIDTH_W-1:0]   width_eff;
   logic                          cmd_ff;
   logic [pba_pkg::VAL_W-1:0]     val_ff;
   pba_pkg::loc_type              loc_ff;
   pba_pkg::loc_type              loc_now;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [pba_pkg::VAL_W-1:0]     rsp_data_ff, rsp_data_in;

   logic                          req_fire;
   logic                          even_we, odd_we;
   logic [pba_pkg::EVEN_AW-1:0]   even_addr;
   logic [pba_pkg::ODD_AW-1:0]    odd_addr;
   logic [7:0]                    even_wdata, odd_wdata;
   logic [7:0]                    even_rdata, odd_rdata;
   logic [7:0]                    lo_byte, hi_byte;
   logic [pba_pkg::VAL_W-1:0]     field;
   logic [7:0]                    new_lo, new_hi;
   logic                          do_write;

   // Width register
   assign csr_bus.ready = 1'b1;
   assign width_eff     = pba_pkg::eff_width(width_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= pba_pkg::WIDTH_RESET;
      end else if (csr_bus.valid) begin
         width_ff <= csr_bus.field_width;
      end
   end

   // Field location of the incoming command
   pba_locate u_locate (
      .index (req_bus.index),
      .width (width_eff),
      .loc   (loc_now)
   );

   // Command transfer
   assign req_bus.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_bus.ready);
   assign req_fire      = req_bus.valid && req_bus.ready;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff <= req_bus.command;
         val_ff <= req_bus.write_value;
         loc_ff <= loc_now;
      end
   end

   // Two-byte window from the banks, read in the cycle before
   always_comb begin
      lo_byte = loc_ff.odd_start ? odd_rdata : even_rdata;
      hi_byte = '0;
      if (loc_ff.has_next) begin
         hi_byte = loc_ff.odd_start ? even_rdata : odd_rdata;
      end
   end

   pba_merge u_merge (
      .lo_byte     (lo_byte),
      .hi_byte     (hi_byte),
      .bit_at      (loc_ff.bit_at),
      .width       (width_eff),
      .write_value (val_ff),
      .field       (field),
      .new_lo      (new_lo),
      .new_hi      (new_hi)
   );

   // Bank port control: clearing pass, read on transfer, write back after
   assign do_write = (state_ff == ST_MOD) && (cmd_ff == pba_pkg::CMD_WRITE) && loc_ff.in_range;

   always_comb begin
      even_we    = 1'b0;
      odd_we     = 1'b0;
      even_addr  = loc_ff.even_addr;
      odd_addr   = loc_ff.odd_addr;
      even_wdata = '0;
      odd_wdata  = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            even_we   = 1'b1;
            odd_we    = 32'(clr_cnt_ff) < 32'(pba_pkg::ODD_DEPTH);
            even_addr = clr_cnt_ff;
            odd_addr  = pba_pkg::ODD_AW'(clr_cnt_ff);
         end
         ST_IDLE: begin
            even_addr = loc_now.even_addr;
            odd_addr  = loc_now.odd_addr;
         end
         ST_MOD: begin
            even_we    = do_write && (!loc_ff.odd_start || loc_ff.has_next);
            odd_we     = do_write && (loc_ff.odd_start || loc_ff.has_next);
            even_wdata = loc_ff.odd_start ? new_hi : new_lo;
            odd_wdata  = loc_ff.odd_start ? new_lo : new_hi;
         end
         default: begin
         end
      endcase
   end

   pba_ram #(.WIDTH(8), .DEPTH(pba_pkg::EVEN_DEPTH)) u_even_ram (
      .clock (clock),
      .we    (even_we),
      .addr  (even_addr),
      .wdata (even_wdata),
      .rdata (even_rdata)
   );

   pba_ram #(.WIDTH(8), .DEPTH(pba_pkg::ODD_DEPTH)) u_odd_ram (
      .clock (clock),
      .we    (odd_we),
      .addr  (odd_addr),
      .wdata (odd_wdata),
      .rdata (odd_rdata)
   );

   // Sequencer and result register
   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + pba_pkg::EVEN_AW'(1);
            if (clr_cnt_ff == pba_pkg::EVEN_AW'(pba_pkg::EVEN_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            state_in = ST_IDLE;
            if (cmd_ff == pba_pkg::CMD_READ) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = loc_ff.in_range ? field : '0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.read_value = rsp_data_ff;

   // A result appears only after the merge cycle of a read
   a_rsp_from_mod: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_MOD))
      else $error("result raised outside the merge cycle");

   // No command is taken during the clearing pass
   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !req_bus.ready)
      else $error("command taken while clearing");

   // The merge state is always followed by the idle state
   a_mod_one_cycle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MOD |=> state_ff == ST_IDLE)
      else $error("merge cycle did not end");

   // The banks are written only by clearing or by a write command's merge cycle
   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !(even_we || odd_we))
      else $error("bank written while idle");

   // A result register that is full is never overwritten by a new read
   a_no_rsp_overrun: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MOD) && (cmd_ff == pba_pkg::CMD_READ) |-> !rsp_valid_ff)
      else $error("result register overrun");

endmodule

`default_nettype wire
